### hw/rtl/pstp_pkg.sv
// ----------------------------------------------------------------------------
// pstp_pkg
// Types and constants shared by the tune parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pstp_pkg;

  localparam int DIVIDEND_W = 28;
  localparam int DIVISOR_W  = 16;

  localparam logic [DIVIDEND_W-1:0] WHOLE_DIVIDEND = 28'd240000000;
  localparam logic [23:0]           WHOLE_AT_RESET = 24'd2000000;
  localparam logic [15:0]           LEN_AT_RESET   = 16'd4;
  localparam logic [2:0]            OCT_AT_RESET   = 3'd4;
  localparam logic [6:0]            TOP_NOTE       = 7'd84;
  localparam logic [15:0]           TEMPO_MIN      = 16'd32;
  localparam logic [15:0]           TEMPO_MAX      = 16'd255;
  localparam logic [15:0]           NUM_MAX        = 16'hFFFF;

  localparam logic [1:0] KIND_NOTE = 2'd0;
  localparam logic [1:0] KIND_REST = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;
  localparam logic [1:0] KIND_ERR  = 2'd3;

  localparam logic [1:0] ART_NORMAL   = 2'd0;
  localparam logic [1:0] ART_LEGATO   = 2'd1;
  localparam logic [1:0] ART_STACCATO = 2'd2;

  typedef enum logic [3:0] {
    PH_IDLE, PH_MODE, PH_LEN, PH_OCT, PH_TEMPO, PH_NNUM, PH_PNUM,
    PH_ACC, PH_SHORT, PH_NDOTS, PH_RDOTS
  } phase_t;

  typedef enum logic [1:0] {ST_WAIT, ST_PARSE, ST_DIV, ST_FLUSH} back_state_t;

  typedef enum logic [1:0] {DT_WHOLE, DT_NOTE, DT_REST} div_target_t;

  typedef struct packed {
    logic       action;
    logic [7:0] ch;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [6:0]  note_number;
    logic [23:0] play_us;
    logic [23:0] gap_us;
    logic        restart;
    logic        last;
  } result_t;

  function automatic logic [3:0] semitone(input logic [2:0] idx);
    logic [3:0] s;
    unique case (idx)
      3'd0: s = 4'd9;
      3'd1: s = 4'd11;
      3'd2: s = 4'd0;
      3'd3: s = 4'd2;
      3'd4: s = 4'd4;
      3'd5: s = 4'd5;
      3'd6: s = 4'd7;
      default: s = 4'd0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/play_string_tune_parser.sv
// ----------------------------------------------------------------------------
// play_string_tune_parser
// Parser for tunes in the PLAY music language, one character per transaction.
// ----------------------------------------------------------------------------
// Characters enter a two-entry queue and are taken by the parser one at a
// time. A character that completes a note or rest length, or sets a tempo,
// also runs the shared radix-2 divider before the parser takes the next one.
// Results collect in a four-entry queue, and the parser takes a new
// character only while two entries are free, so the result side may stall
// without holding up the input until the queue fills. Whitespace is dropped
// at the input and costs no parser time.
`default_nettype none

module play_string_tune_parser #(
  parameter int DURATION_BITS = 24,
  parameter int MAX_OCTAVE    = 6
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic        action,
  input  wire logic [7:0]  ch,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       kind,
  output logic [6:0]       note_number,
  output logic [23:0]      play_us,
  output logic [23:0]      gap_us,
  output logic             restart,
  output logic             last
);
  import pstp_pkg::*;

  logic    q_valid;
  cmd_t    q_item;
  logic    q_pop;
  logic    res_room;
  logic    res_push;
  result_t res_item;
  result_t head;

  pstp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .action  (action),
    .ch      (ch),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  pstp_back #(
    .DURATION_BITS (DURATION_BITS),
    .MAX_OCTAVE    (MAX_OCTAVE)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .res_room (res_room),
    .res_push (res_push),
    .res_item (res_item)
  );

  pstp_resq u_resq (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_item (res_item),
    .room    (res_room),
    .empty   (empty),
    .pop     (pop),
    .head    (head)
  );

  assign kind        = head.kind;
  assign note_number = head.note_number;
  assign play_us     = head.play_us;
  assign gap_us      = head.gap_us;
  assign restart     = head.restart;
  assign last        = head.last;

endmodule

`default_nettype wire

### hw/rtl/pstp_front.sv
// ----------------------------------------------------------------------------
// pstp_front
// Takes input transactions, drops whitespace, folds lower case letters and
// holds the characters in a two-entry queue for the parser.
// ----------------------------------------------------------------------------
`default_nettype none

module pstp_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  output logic               full,
  input  wire logic          action,
  input  wire logic [7:0]    ch,
  output logic               q_valid,
  output pstp_pkg::cmd_t     q_item,
  input  wire logic          q_pop
);
  import pstp_pkg::*;

  cmd_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       is_space;
  logic       enq;
  cmd_t       item_in;

  assign full     = (count == 2'd2);
  assign is_space = (ch == 8'd32) || (ch >= 8'd9 && ch <= 8'd13);
  assign enq      = push && !full && !(action && is_space);

  always_comb begin
    item_in.action = action;
    item_in.ch     = ch;
    if (ch >= 8'h61 && ch <= 8'h7A) begin
      item_in.ch = ch - 8'd32;
    end
  end

  assign q_valid = (count != 2'd0);
  assign q_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (enq) begin
      mem[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (enq) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(enq) - 2'(q_pop);
    end
  end

endmodule

`default_nettype wire

### hw/rtl/pstp_div.sv
// ----------------------------------------------------------------------------
// pstp_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pstp_div (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic [pstp_pkg::DIVIDEND_W-1:0]   dividend,
  input  wire logic [pstp_pkg::DIVISOR_W-1:0]    divisor,
  output logic                                   done,
  output logic [pstp_pkg::DIVIDEND_W-1:0]        quotient
);
  import pstp_pkg::*;

  logic                    busy;
  logic [4:0]              cnt;
  logic [DIVISOR_W-1:0]    rem;
  logic [DIVISOR_W-1:0]    dvs;
  logic [DIVISOR_W:0]      trial;
  logic                    ge;

  assign trial = {rem, quotient[DIVIDEND_W-1]};
  assign ge    = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      rem      <= ge ? DIVISOR_W'(trial - {1'b0, dvs}) : trial[DIVISOR_W-1:0];
      quotient <= {quotient[DIVIDEND_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'(DIVIDEND_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/pstp_back.sv
// ----------------------------------------------------------------------------
// pstp_back
// Parser proper: keeps the player settings and the partly parsed command,
// runs durations through the divider and produces result transactions.
// ----------------------------------------------------------------------------
`default_nettype none

module pstp_back #(
  parameter int DURATION_BITS = 24,
  parameter int MAX_OCTAVE    = 6
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_valid,
  input  wire pstp_pkg::cmd_t   q_item,
  output logic                  q_pop,
  input  wire logic             res_room,
  output logic                  res_push,
  output pstp_pkg::result_t     res_item
);
  import pstp_pkg::*;

  localparam logic [2:0]  OCT_TOP = 3'(MAX_OCTAVE);
  localparam logic [32:0] DUR_LIM = (33'd1 << DURATION_BITS) - 33'd1;

  back_state_t state, state_next;
  div_target_t dtarget, dtarget_next;
  phase_t      phase, phase_next;

  logic [23:0] whole, whole_next;
  logic [15:0] deflen, deflen_next;
  logic [2:0]  oct, oct_next;
  logic [1:0]  art, art_next;
  logic        rep, rep_next;
  logic        active, active_next;
  logic [15:0] acc, acc_next;
  logic [6:0]  pnote, pnote_next;
  logic [23:0] period, period_next;
  logic [23:0] ext, ext_next;
  logic [23:0] gap, gap_next;
  logic [7:0]  c, c_next;
  result_t     held, held_next;
  logic        held_v, held_v_next;

  logic        start_player;
  logic        fin;
  logic        put;
  result_t     put_res;
  logic        div_start;
  logic [DIVIDEND_W-1:0] div_dividend;
  logic [DIVISOR_W-1:0]  div_divisor;
  logic        div_done;
  logic [DIVIDEND_W-1:0] div_q;

  logic        digit;
  logic [19:0] acc_mul;
  logic [15:0] acc_sat;
  logic [6:0]  letter_note;
  logic [32:0] dot_sum;
  logic [32:0] dot_sat;
  logic [23:0] q24;
  logic [23:0] note_gap;

  pstp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  assign digit   = (c >= 8'h30) && (c <= 8'h39);
  assign acc_mul = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + 20'(c[3:0]);
  assign acc_sat = (acc_mul > 20'(NUM_MAX)) ? NUM_MAX : acc_mul[15:0];
  assign letter_note = 7'(semitone(c[2:0] - 3'd1)) + 7'({oct, 3'b0}) + 7'({oct, 2'b0})
                       + 7'd1;
  assign dot_sum  = 33'(period) + 33'(ext);
  assign dot_sat  = (dot_sum > DUR_LIM) ? DUR_LIM : dot_sum;
  assign q24      = div_q[23:0];
  assign note_gap = (art == ART_NORMAL) ? (q24 >> 3) :
                    (art == ART_STACCATO) ? (q24 >> 2) : 24'd0;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_WAIT: begin
        if (q_valid && res_room && q_item.action && active) begin
          state_next = ST_PARSE;
        end
      end
      ST_PARSE: begin
        if (div_start) begin
          state_next = ST_DIV;
        end else if (fin) begin
          state_next = held_v_next ? ST_FLUSH : ST_WAIT;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_PARSE;
        end
      end
      ST_FLUSH: state_next = ST_WAIT;
      default:  state_next = ST_WAIT;
    endcase
  end

  always_comb begin
    dtarget_next = dtarget;
    phase_next   = phase;
    whole_next   = whole;
    deflen_next  = deflen;
    oct_next     = oct;
    art_next     = art;
    rep_next     = rep;
    active_next  = active;
    acc_next     = acc;
    pnote_next   = pnote;
    period_next  = period;
    ext_next     = ext;
    gap_next     = gap;
    c_next       = c;
    held_next    = held;
    held_v_next  = held_v;
    start_player = 1'b0;
    fin          = 1'b0;
    put          = 1'b0;
    put_res      = '0;
    div_start    = 1'b0;
    div_dividend = {4'b0, whole};
    div_divisor  = deflen;
    q_pop        = 1'b0;
    res_push     = 1'b0;
    res_item     = held;

    unique case (state)
      ST_WAIT: begin
        if (q_valid && res_room) begin
          q_pop  = 1'b1;
          c_next = q_item.ch;
          if (!q_item.action) begin
            start_player = 1'b1;
            active_next  = 1'b1;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          unique case (dtarget)
            DT_WHOLE: whole_next = q24;
            DT_NOTE: begin
              gap_next    = note_gap;
              period_next = q24 - note_gap;
              ext_next    = (q24 - note_gap) >> 1;
            end
            default: begin
              gap_next    = 24'd0;
              period_next = q24;
              ext_next    = q24 >> 1;
            end
          endcase
        end
      end
      ST_FLUSH: begin
        res_push      = 1'b1;
        res_item.last = 1'b1;
        held_v_next   = 1'b0;
      end
      ST_PARSE: begin
        put_res.kind = KIND_ERR;
        unique case (phase)
          PH_MODE: begin
            phase_next = PH_IDLE;
            fin        = 1'b1;
            if (c == "N") art_next = ART_NORMAL;
            else if (c == "L") art_next = ART_LEGATO;
            else if (c == "S") art_next = ART_STACCATO;
            else if (c == "F") rep_next = 1'b0;
            else if (c == "B") rep_next = 1'b1;
            else put = 1'b1;
          end
          PH_LEN: begin
            if (digit) begin
              acc_next = acc_sat;
              fin      = 1'b1;
            end else if (acc == 16'd0) begin
              put = 1'b1;
              fin = 1'b1;
            end else begin
              deflen_next = acc;
              phase_next  = PH_IDLE;
            end
          end
          PH_OCT: begin
            if (digit) begin
              acc_next = acc_sat;
              fin      = 1'b1;
            end else begin
              oct_next   = (acc > 16'(OCT_TOP)) ? OCT_TOP : acc[2:0];
              phase_next = PH_IDLE;
            end
          end
          PH_TEMPO: begin
            if (digit) begin
              acc_next = acc_sat;
              fin      = 1'b1;
            end else if (acc < TEMPO_MIN || acc > TEMPO_MAX) begin
              put = 1'b1;
              fin = 1'b1;
            end else begin
              phase_next   = PH_IDLE;
              div_start    = 1'b1;
              dtarget_next = DT_WHOLE;
              div_dividend = WHOLE_DIVIDEND;
              div_divisor  = acc;
            end
          end
          PH_NNUM: begin
            if (digit) begin
              acc_next = acc_sat;
              fin      = 1'b1;
            end else if (acc > 16'(TOP_NOTE)) begin
              put = 1'b1;
              fin = 1'b1;
            end else begin
              div_start = 1'b1;
              if (acc == 16'd0) begin
                dtarget_next = DT_REST;
                phase_next   = PH_RDOTS;
              end else begin
                pnote_next   = acc[6:0];
                dtarget_next = DT_NOTE;
                phase_next   = PH_NDOTS;
              end
            end
          end
          PH_PNUM: begin
            if (digit) begin
              acc_next = acc_sat;
              fin      = 1'b1;
            end else begin
              div_start    = 1'b1;
              dtarget_next = DT_REST;
              phase_next   = PH_RDOTS;
              div_divisor  = (acc == 16'd0) ? 16'd1 : acc;
            end
          end
          PH_ACC: begin
            acc_next   = 16'd0;
            phase_next = PH_SHORT;
            if (c == "#" || c == "+") begin
              if (pnote < TOP_NOTE) pnote_next = pnote + 7'd1;
              fin = 1'b1;
            end else if (c == "-") begin
              if (pnote > 7'd1) pnote_next = pnote - 7'd1;
              fin = 1'b1;
            end
          end
          PH_SHORT: begin
            if (digit) begin
              acc_next = acc_sat;
              fin      = 1'b1;
            end else begin
              div_start    = 1'b1;
              dtarget_next = DT_NOTE;
              phase_next   = PH_NDOTS;
              div_divisor  = (acc == 16'd0) ? deflen : acc;
            end
          end
          PH_NDOTS, PH_RDOTS: begin
            if (c == ".") begin
              period_next = dot_sat[23:0];
              ext_next    = ext >> 1;
              fin         = 1'b1;
            end else begin
              put        = 1'b1;
              phase_next = PH_IDLE;
              if (phase == PH_NDOTS) begin
                put_res.kind        = KIND_NOTE;
                put_res.note_number = pnote;
                put_res.play_us     = period;
                put_res.gap_us      = gap;
              end else begin
                put_res.kind    = KIND_REST;
                put_res.play_us = period;
              end
            end
          end
          default: begin
            phase_next = PH_IDLE;
            acc_next   = 16'd0;
            fin        = 1'b1;
            if (c == 8'd0) begin
              put             = 1'b1;
              put_res.kind    = KIND_END;
              put_res.restart = rep;
              if (rep) start_player = 1'b1;
              else active_next = 1'b0;
            end else if (c == "L") phase_next = PH_LEN;
            else if (c == "O") phase_next = PH_OCT;
            else if (c == "T") phase_next = PH_TEMPO;
            else if (c == "N") phase_next = PH_NNUM;
            else if (c == "P") phase_next = PH_PNUM;
            else if (c == "M") phase_next = PH_MODE;
            else if (c == "<") begin
              if (oct != 3'd0) oct_next = oct - 3'd1;
            end else if (c == ">") begin
              if (oct < OCT_TOP) oct_next = oct + 3'd1;
            end else if (c >= "A" && c <= "G") begin
              pnote_next = (letter_note > TOP_NOTE) ? TOP_NOTE : letter_note;
              phase_next = PH_ACC;
            end else begin
              put = 1'b1;
            end
          end
        endcase
        if (put && put_res.kind == KIND_ERR) begin
          rep_next    = 1'b0;
          active_next = 1'b0;
          phase_next  = PH_IDLE;
        end
        if (put) begin
          if (held_v) begin
            res_push      = 1'b1;
            res_item.last = 1'b0;
          end
          held_next   = put_res;
          held_v_next = 1'b1;
        end
      end
      default: ;
    endcase

    if (start_player) begin
      whole_next  = WHOLE_AT_RESET;
      deflen_next = LEN_AT_RESET;
      oct_next    = OCT_AT_RESET;
      art_next    = ART_NORMAL;
      rep_next    = 1'b0;
      phase_next  = PH_IDLE;
      acc_next    = 16'd0;
      pnote_next  = 7'd0;
      period_next = 24'd0;
      ext_next    = 24'd0;
      gap_next    = 24'd0;
    end
  end

  always_ff @(posedge clk) begin
    c       <= c_next;
    held    <= held_next;
    dtarget <= dtarget_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_WAIT;
      phase  <= PH_IDLE;
      whole  <= WHOLE_AT_RESET;
      deflen <= LEN_AT_RESET;
      oct    <= OCT_AT_RESET;
      art    <= ART_NORMAL;
      rep    <= 1'b0;
      active <= 1'b0;
      acc    <= 16'd0;
      pnote  <= 7'd0;
      period <= 24'd0;
      ext    <= 24'd0;
      gap    <= 24'd0;
      held_v <= 1'b0;
    end else begin
      state  <= state_next;
      phase  <= phase_next;
      whole  <= whole_next;
      deflen <= deflen_next;
      oct    <= oct_next;
      art    <= art_next;
      rep    <= rep_next;
      active <= active_next;
      acc    <= acc_next;
      pnote  <= pnote_next;
      period <= period_next;
      ext    <= ext_next;
      gap    <= gap_next;
      held_v <= held_v_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/pstp_resq.sv
// ----------------------------------------------------------------------------
// pstp_resq
// Four-entry result queue between the parser and the result port.
// ----------------------------------------------------------------------------
`default_nettype none

module pstp_resq (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                wr_en,
  input  wire pstp_pkg::result_t   wr_item,
  output logic                     room,
  output logic                     empty,
  input  wire logic                pop,
  output pstp_pkg::result_t        head
);
  import pstp_pkg::*;

  result_t    mem [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic       rd_en;

  assign empty = (count == 3'd0);
  assign room  = (count <= 3'd2);
  assign rd_en = pop && !empty;
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 2'd1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + 3'(wr_en) - 3'(rd_en);
    end
  end

endmodule

`default_nettype wire

### hw/rtl/pstp_checker.sv
// ----------------------------------------------------------------------------
// pstp_checker
// Port-level checks on the tune parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pstp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [1:0]  kind,
  input wire logic [6:0]  note_number,
  input wire logic [23:0] play_us,
  input wire logic [23:0] gap_us,
  input wire logic        restart
);
  import pstp_pkg::*;

  a_empty_after_reset: assert property (@(posedge clk) rst |=> empty)
    else $error("Result queue is not empty after reset.");

  a_note_range: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind == KIND_NOTE) |-> (note_number >= 7'd1 && note_number <= TOP_NOTE))
    else $error("Note number out of range.");

  a_non_note_clear: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind != KIND_NOTE) |-> (note_number == 7'd0 && gap_us == 24'd0))
    else $error("Non-note result carries note fields.");

  a_restart_only_end: assert property (@(posedge clk) disable iff (rst)
    (!empty && restart) |-> (kind == KIND_END))
    else $error("Restart set on a result that is not a tune end.");

  a_head_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(play_us) && $stable(kind)))
    else $error("Waiting result changed before it was taken.");

endmodule

bind play_string_tune_parser pstp_checker u_pstp_checker (
  .clk         (clk),
  .rst         (rst),
  .empty       (empty),
  .pop         (pop),
  .kind        (kind),
  .note_number (note_number),
  .play_us     (play_us),
  .gap_us      (gap_us),
  .restart     (restart)
);

`default_nettype wire

### test/play_string_tune_parser_tb.sv
// ----------------------------------------------------------------------------
// play_string_tune_parser_tb
// Self-checking testbench for the PLAY tune parser.
// ----------------------------------------------------------------------------
// A directed table covers reset values, extremes, several commands and the error
// cases. Random tunes follow, mostly well formed with random content and some
// noise. Every result transaction is compared against a behavioral predictor
// of the parser, under several idling phases on both sides.
`default_nettype none

module play_string_tune_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pstp_pkg::*;

  localparam int MAX_OCT = 6;
  localparam int DUR_BITS = 24;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic action = 1'b0;
  logic [7:0] ch = 8'd0;
  logic pop = 1'b0;
  logic full, empty, restart, last;
  logic [1:0] kind;
  logic [6:0] note_number;
  logic [23:0] play_us, gap_us;

  play_string_tune_parser u_top (
    .clk(clk), .rst(rst), .push(push), .full(full), .action(action), .ch(ch),
    .empty(empty), .pop(pop), .kind(kind), .note_number(note_number),
    .play_us(play_us), .gap_us(gap_us), .restart(restart), .last(last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #100ms;
    $display("FAIL play_string_tune_parser");
    $finish;
  end

  // Predictor state.
  int unsigned tempo, dlen, octave, artic, rep_flag, active, phase;
  int unsigned num, pnote, pperiod, dotext, pgap;
  result_t expected_results[$];
  result_t row_first;
  bit row_any = 1'b0;
  int errors = 0;
  int send_idle = 0;
  int recv_idle = 0;

  function automatic int unsigned sat_dur(longint unsigned v);
    longint unsigned lim = (64'd1 << DUR_BITS) - 1;
    return 32'((v > lim) ? lim : v) & 32'hFFFFFF;
  endfunction

  function automatic void player_start();
    tempo = 120; dlen = 4; octave = 4; artic = ART_NORMAL; rep_flag = 0;
    phase = PH_IDLE; num = 0; pnote = 0; pperiod = 0; dotext = 0; pgap = 0;
  endfunction

  function automatic void ref_init();
    player_start();
    active = 0;
  endfunction

  function automatic int unsigned whole_us();
    return 240000000 / (tempo ? tempo : 1);
  endfunction

  function automatic void add_result(logic [1:0] k, int unsigned n, int unsigned p,
                                     int unsigned g, int unsigned r);
    result_t x;
    x.kind = k; x.note_number = n[6:0]; x.play_us = p[23:0];
    x.gap_us = g[23:0]; x.restart = r[0]; x.last = 1'b0;
    expected_results.push_back(x);
  endfunction

  function automatic void setup_note(int unsigned len);
    int unsigned p, g;
    p = whole_us() / (len ? len : 1);
    g = 0;
    if (artic == ART_NORMAL) g = p / 8;
    else if (artic == ART_STACCATO) g = p / 4;
    p -= g;
    pgap = sat_dur(g); pperiod = sat_dur(p); dotext = pperiod / 2;
  endfunction

  function automatic void setup_rest(int unsigned len);
    pperiod = sat_dur(whole_us() / (len ? len : 1));
    pgap = 0; dotext = pperiod / 2;
  endfunction

  function automatic void accumulate(int unsigned c);
    int unsigned v = num * 10 + (c - 48);
    num = (v > 65535) ? 65535 : v;
  endfunction

  function automatic void raise_error();
    add_result(KIND_ERR, 0, 0, 0, 0);
    rep_flag = 0; active = 0; phase = PH_IDLE;
  endfunction

  // Returns after updating state and appending the results of one character.
  function automatic void parse_char(int unsigned c, bit dig);
    int unsigned v;
    int unsigned semis[7] = '{9, 11, 0, 2, 4, 5, 7};
    forever begin
      case (phase)
        PH_MODE: begin
          phase = PH_IDLE;
          if (c == "N") artic = ART_NORMAL;
          else if (c == "L") artic = ART_LEGATO;
          else if (c == "S") artic = ART_STACCATO;
          else if (c == "F") rep_flag = 0;
          else if (c == "B") rep_flag = 1;
          else raise_error();
          return;
        end
        PH_LEN: begin
          if (dig) begin accumulate(c); return; end
          if (num == 0) begin raise_error(); return; end
          dlen = num; phase = PH_IDLE;
        end
        PH_OCT: begin
          if (dig) begin accumulate(c); return; end
          octave = (num > MAX_OCT) ? MAX_OCT : num; phase = PH_IDLE;
        end
        PH_TEMPO: begin
          if (dig) begin accumulate(c); return; end
          if (num < 32 || num > 255) begin raise_error(); return; end
          tempo = num; phase = PH_IDLE;
        end
        PH_NNUM: begin
          if (dig) begin accumulate(c); return; end
          if (num > 84) begin raise_error(); return; end
          if (num == 0) begin
            setup_rest(dlen); phase = PH_RDOTS;
          end else begin
            pnote = num; setup_note(dlen); phase = PH_NDOTS;
          end
        end
        PH_PNUM: begin
          if (dig) begin accumulate(c); return; end
          setup_rest(num); phase = PH_RDOTS;
        end
        PH_ACC: begin
          num = 0; phase = PH_SHORT;
          if (c == "#" || c == "+") begin
            if (pnote < 84) pnote++;
            return;
          end
          if (c == "-") begin
            if (pnote > 1) pnote--;
            return;
          end
        end
        PH_SHORT: begin
          if (dig) begin accumulate(c); return; end
          setup_note(num ? num : dlen); phase = PH_NDOTS;
        end
        PH_NDOTS, PH_RDOTS: begin
          if (c == ".") begin
            pperiod = sat_dur(longint'(pperiod) + dotext); dotext /= 2;
            return;
          end
          if (phase == PH_NDOTS) add_result(KIND_NOTE, pnote, pperiod, pgap, 0);
          else add_result(KIND_REST, 0, pperiod, 0, 0);
          phase = PH_IDLE;
        end
        default: begin
          phase = PH_IDLE; num = 0;
          if (c == 0) begin
            v = rep_flag;
            add_result(KIND_END, 0, 0, 0, v);
            if (v != 0) player_start();
            else active = 0;
          end else if (c == "L") phase = PH_LEN;
          else if (c == "O") phase = PH_OCT;
          else if (c == "T") phase = PH_TEMPO;
          else if (c == "N") phase = PH_NNUM;
          else if (c == "P") phase = PH_PNUM;
          else if (c == "M") phase = PH_MODE;
          else if (c == "<") begin if (octave > 0) octave--; end
          else if (c == ">") begin if (octave < MAX_OCT) octave++; end
          else if (c >= "A" && c <= "G") begin
            v = semis[c - 65] + octave * 12 + 1;
            pnote = (v > 84) ? 84 : v; phase = PH_ACC;
          end else raise_error();
          return;
        end
      endcase
    end
  endfunction

  function automatic void predict_parse(logic act, logic [7:0] chr);
    int unsigned c = chr;
    int base = expected_results.size();
    row_any = 1'b0;
    if (!act) begin
      player_start(); active = 1; return;
    end
    if (!active) return;
    if (c == 32 || (c >= 9 && c <= 13)) return;
    if (c >= "a" && c <= "z") c -= 32;
    parse_char(c, c >= "0" && c <= "9");
    if (expected_results.size() > base) begin
      expected_results[expected_results.size() - 1].last = 1'b1;
      row_any = 1'b1;
      row_first = expected_results[base];
    end
  endfunction

  // Result side: random stalls, compare at the rising edge.
  always @(posedge clk) begin
    result_t got, want;
    if (!rst && pop && !empty) begin
      got = '{kind, note_number, play_us, gap_us, restart, last};
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected %p actual %p", $time, want, got);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    pop <= !rst && ($urandom_range(99) >= recv_idle);
  end

  // Directed check with a typed-in result that the predictor's first result must match.
  typedef struct {
    logic act;
    logic [7:0] chr;
    bit chk;
    logic [1:0] k;
    int unsigned p;
  } stim_row_t;

  stim_row_t dir_tab[$] = '{
    '{1'b1, "C", 0, 0, 0},                 // inactive, ignored
    '{1'b0, 8'd0, 0, 0, 0},
    '{1'b1, "c", 0, 0, 0},
    '{1'b1, 8'd0, 1, KIND_NOTE, 437500},  // quarter at 120 minus 1/8 gap
    '{1'b0, 8'd0, 0, 0, 0},
    '{1'b1, "t", 0, 0, 0},
    '{1'b1, "9", 0, 0, 0},
    '{1'b1, "9", 0, 0, 0},
    '{1'b1, "9", 0, 0, 0},
    '{1'b1, "9", 0, 0, 0},
    '{1'b1, "9", 0, 0, 0},
    '{1'b1, "9", 0, 0, 0},
    '{1'b1, 8'd0, 1, KIND_ERR, 0},        // tempo saturates, then error
    '{1'b0, 8'd0, 0, 0, 0},
    '{1'b1, "M", 0, 0, 0},
    '{1'b1, 8'hFF, 1, KIND_ERR, 0},
    '{1'b0, 8'd0, 0, 0, 0},
    '{1'b1, "P", 0, 0, 0},
    '{1'b1, "0", 0, 0, 0},
    '{1'b1, ".", 0, 0, 0},
    '{1'b1, 8'h80, 0, KIND_REST, 0},
    '{1'b0, 8'd0, 0, 0, 0},
    '{1'b1, "L", 0, 0, 0},
    '{1'b1, "0", 0, 0, 0},
    '{1'b1, " ", 0, 0, 0},
    '{1'b1, "N", 1, KIND_ERR, 0}
  };

  task automatic send_item(logic act, logic [7:0] chr);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1; action <= act; ch <= chr;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_parse(act, chr);
    @(negedge clk);
  endtask

  function automatic string number_text(int unsigned v);
    return $sformatf("%0d", v);
  endfunction

  // Builds one random tune body, mostly valid commands.
  function automatic string random_tune();
    string s = "";
    string letters = "ABCDEFG";
    string modes = "NLSFB";
    int n = $urandom_range(12, 2);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(14))
        0: s = {s, "L", number_text($urandom_range(64, 1))};
        1: s = {s, "O", number_text($urandom_range(9))};
        2: s = {s, ($urandom_range(1) ? "<" : ">")};
        3: s = {s, "M", string'(modes[$urandom_range(4)])};
        4: s = {s, "T", number_text($urandom_range(300, 20))};
        5: s = {s, "N", number_text($urandom_range(90))};
        6: s = {s, "P", number_text($urandom_range(70))};
        7: s = {s, "n", number_text($urandom_range(84)), "."};
        8: s = {s, ($urandom_range(1) ? " " : "\t")};
        9: s = {s, string'(8'($urandom_range(255, 1)))};
        10: s = {s, "P", number_text($urandom_range(99999)), ".."};
        default: begin
          s = {s, string'(letters[$urandom_range(6)])};
          case ($urandom_range(3))
            0: s = {s, "#"};
            1: s = {s, "-"};
            2: s = {s, "+"};
            default: ;
          endcase
          if ($urandom_range(1)) s = {s, number_text($urandom_range(64))};
          repeat ($urandom_range(3) == 0 ? $urandom_range(3, 1) : 0) s = {s, "."};
        end
      endcase
    end
    return s;
  endfunction

  initial begin
    int sent;
    string t;
    ref_init();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      send_item(dir_tab[i].act, dir_tab[i].chr);
      if (dir_tab[i].chk) begin
        if (!row_any || row_first.kind !== dir_tab[i].k ||
            (dir_tab[i].p != 0 && row_first.play_us !== dir_tab[i].p[23:0])) begin
          $display("%0t: directed row %0d expected kind %0d play %0d actual %p", $time,
                   i, dir_tab[i].k, dir_tab[i].p, row_first);
          errors++;
        end
      end
    end

    sent = 0;
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = (ph == 1 || ph == 3) ? ((ph == 3) ? 33 : 47) : 0;
      recv_idle = (ph == 2 || ph == 3) ? ((ph == 3) ? 33 : 47) : 0;
      while (sent < (ph + 1) * 235) begin
        send_item(1'b0, 8'd0);
        if ($urandom_range(9) == 0) send_item(1'b0, 8'd0);
        t = random_tune();
        if ($urandom_range(3) == 0) t = {t, "MB"};
        for (int i = 0; i < t.len(); i++) begin
          send_item(1'b1, t[i]);
          sent++;
        end
        send_item(1'b1, 8'd0);
        if ($urandom_range(1)) send_item(1'b1, "c");
        sent += 2;
      end
    end
    push <= 1'b0;
    send_idle = 0;
    recv_idle = 0;

    while (expected_results.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("PASS play_string_tune_parser");
    end else begin
      $display("FAIL play_string_tune_parser");
    end
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
hw/rtl/pstp_pkg.sv
hw/rtl/pstp_front.sv
hw/rtl/pstp_div.sv
hw/rtl/pstp_back.sv
hw/rtl/pstp_resq.sv
hw/rtl/play_string_tune_parser.sv
hw/rtl/pstp_checker.sv
test/play_string_tune_parser_tb.sv
